// ===== hdl/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg
// Types and constants shared by the finite state transducer.
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int MaxStates   = 8;
   localparam int MaxOutChars = 8;
   localparam int Alphabet    = 26;
   localparam int TableDepth  = MaxStates * MaxStates * Alphabet;

   localparam int StateW   = $clog2(MaxStates);
   localparam int CountW   = $clog2(MaxStates + 1);
   localparam int LetterW  = 5;
   localparam int LenW     = $clog2(MaxOutChars + 1);
   localparam int CharIdxW = (MaxOutChars > 1) ? $clog2(MaxOutChars) : 1;
   localparam int CharW    = 8;
   localparam int TextW    = MaxOutChars * CharW;
   localparam int AddrW    = $clog2(TableDepth);
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 4;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LETTER = 1'b1;

   localparam logic [CsrIdxW-1:0] REG_INITIAL_STATE = 1'd0;
   localparam logic [CsrIdxW-1:0] REG_NUM_STATES    = 1'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT,
      ST_ERROR
   } fsm_state_type;

   typedef struct packed {
      logic clr_wr;
      logic load_wr;
      logic take_letter;
      logic scan_rd;
      logic scan_hit;
      logic scan_next;
      logic emit_char;
      logic emit_err;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic rejected;
      logic no_scan;
      logic hit;
      logic scan_last;
      logic out_free;
      logic emit_last;
   } ctl_status_type;

endpackage

// ===== hdl/fst_req_if.sv =====
// ----------------------------------------------------------------------------
// fst_req_if
// Request channel: table loads and letters to transduce.
// ----------------------------------------------------------------------------
interface fst_req_if;
   import fst_pkg::*;

   logic                valid;
   logic                ready;
   logic                cmd;
   logic [StateW-1:0]   from_state;
   logic [StateW-1:0]   to_state;
   logic [LetterW-1:0]  letter;
   logic                first_letter;
   logic [3:0]          out_length;
   logic [CharIdxW-1:0] char_position;
   logic [CharW-1:0]    char_value;

   modport source (output valid, cmd, from_state, to_state, letter, first_letter,
                   out_length, char_position, char_value, input ready);
   modport sink (input valid, cmd, from_state, to_state, letter, first_letter,
                 out_length, char_position, char_value, output ready);
endinterface

// ===== hdl/fst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fst_rsp_if
// Response channel: one emitted character or one error per transaction.
// ----------------------------------------------------------------------------
interface fst_rsp_if;
   import fst_pkg::*;

   logic              valid;
   logic              ready;
   logic [CharW-1:0]  out_char;
   logic              last_char;
   logic              word_error;
   logic [StateW-1:0] next_state;

   modport source (output valid, out_char, last_char, word_error, next_state,
                   input ready);
   modport sink (input valid, out_char, last_char, word_error, next_state,
                 output ready);
endinterface

// ===== hdl/fst_csr_if.sv =====
// ----------------------------------------------------------------------------
// fst_csr_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface fst_csr_if;
   import fst_pkg::*;

   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fst_ctrl
// Sequencer: table clear, transition scan, character emission.
// ----------------------------------------------------------------------------
module fst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   input  fst_pkg::ctl_status_type status,
   output fst_pkg::ctl_cmd_type    ctl,
   output fst_pkg::fsm_state_type  state
);
   import fst_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_wr = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_LETTER) begin
                  ctl.take_letter = 1'b1;
                  state_in        = ST_START;
               end else begin
                  ctl.load_wr = 1'b1;
               end
            end
         end
         ST_START: begin
            priority if (status.rejected) begin
               state_in = ST_IDLE;
            end else if (status.no_scan) begin
               state_in = ST_ERROR;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            ctl.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            priority if (status.hit) begin
               ctl.scan_hit = 1'b1;
               state_in     = ST_EMIT;
            end else if (status.scan_last) begin
               state_in = ST_ERROR;
            end else begin
               ctl.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               ctl.emit_char = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERROR: begin
            if (status.out_free) begin
               ctl.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ===== hdl/fst_dpath.sv =====
// ----------------------------------------------------------------------------
// fst_dpath
// Transition table, state registers, scan and emission datapath.
// ----------------------------------------------------------------------------
module fst_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  fst_pkg::ctl_cmd_type         ctl,
   output fst_pkg::ctl_status_type      status,
   input  logic [fst_pkg::StateW-1:0]   req_from_state,
   input  logic [fst_pkg::StateW-1:0]   req_to_state,
   input  logic [fst_pkg::LetterW-1:0]  req_letter,
   input  logic                         req_first_letter,
   input  logic [3:0]                   req_out_length,
   input  logic [fst_pkg::CharIdxW-1:0] req_char_position,
   input  logic [fst_pkg::CharW-1:0]    req_char_value,
   input  logic                         csr_wr,
   input  logic [fst_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fst_pkg::CsrDataW-1:0] csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fst_pkg::CharW-1:0]    rsp_out_char,
   output logic                         rsp_last_char,
   output logic                         rsp_word_error,
   output logic [fst_pkg::StateW-1:0]   rsp_next_state
);
   import fst_pkg::*;

   logic [TextW-1:0] text_mem [TableDepth];
   logic [LenW-1:0]  len_mem  [TableDepth];

   logic [StateW-1:0]   initial_state_ff;
   logic [CountW-1:0]   num_states_ff;
   logic [AddrW-1:0]    clr_addr_ff;
   logic [StateW-1:0]   cur_state_ff;
   logic                rejected_ff;
   logic [LetterW-1:0]  letter_ff;
   logic [CountW-1:0]   limit_ff;
   logic [StateW-1:0]   dst_ff;
   logic [CharIdxW-1:0] emit_idx_ff;
   logic [TextW-1:0]    text_rd_ff;
   logic [LenW-1:0]     len_rd_ff;
   logic                rsp_valid_ff;
   logic [CharW-1:0]    out_char_ff;
   logic                last_char_ff;
   logic                word_error_ff;
   logic [StateW-1:0]   next_state_ff;

   logic [AddrW-1:0] wr_addr;
   logic [AddrW-1:0] rd_addr;
   logic             load_ok;
   logic [LenW-1:0]  load_len;
   logic [CountW-1:0] limit;
   logic             emit_last;

   assign wr_addr = AddrW'({req_from_state, req_to_state}) * AddrW'(Alphabet)
                    + AddrW'(req_letter);
   assign rd_addr = AddrW'({cur_state_ff, dst_ff}) * AddrW'(Alphabet)
                    + AddrW'(letter_ff);
   assign load_ok  = ctl.load_wr && (req_letter < LetterW'(Alphabet));
   assign load_len = (req_out_length > 4'(MaxOutChars)) ? LenW'(MaxOutChars)
                                                        : LenW'(req_out_length);
   assign limit = (num_states_ff > CountW'(MaxStates)) ? CountW'(MaxStates)
                                                       : num_states_ff;
   assign emit_last = ((LenW'(emit_idx_ff) + LenW'(1)) == len_rd_ff);

   // table write port: clearing sweep or one character load
   always_ff @(posedge clock) begin
      if (ctl.clr_wr) begin
         text_mem[clr_addr_ff] <= '0;
         len_mem[clr_addr_ff]  <= '0;
      end else if (load_ok) begin
         text_mem[wr_addr][{req_char_position, 3'b000} +: CharW] <= req_char_value;
         len_mem[wr_addr] <= load_len;
      end
   end

   // table read port
   always_ff @(posedge clock) begin
      if (ctl.scan_rd) begin
         text_rd_ff <= text_mem[rd_addr];
         len_rd_ff  <= len_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_state_ff <= '0;
         num_states_ff    <= CountW'(MaxStates);
         clr_addr_ff      <= '0;
         cur_state_ff     <= '0;
         rejected_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               REG_INITIAL_STATE: initial_state_ff <= csr_data[StateW-1:0];
               REG_NUM_STATES:    num_states_ff    <= csr_data[CountW-1:0];
               default:           ;
            endcase
         end
         if (ctl.clr_wr) begin
            clr_addr_ff <= clr_addr_ff + AddrW'(1);
         end
         priority if (ctl.take_letter && req_first_letter) begin
            cur_state_ff <= initial_state_ff;
            rejected_ff  <= 1'b0;
         end else if (ctl.scan_hit) begin
            cur_state_ff <= dst_ff;
         end else if (ctl.emit_err) begin
            rejected_ff <= 1'b1;
         end else begin
            cur_state_ff <= cur_state_ff;
         end
         priority if (ctl.emit_char || ctl.emit_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take_letter) begin
         letter_ff <= req_letter;
         limit_ff  <= limit;
         dst_ff    <= '0;
      end else if (ctl.scan_next) begin
         dst_ff <= dst_ff + StateW'(1);
      end
      if (ctl.scan_hit) begin
         emit_idx_ff <= '0;
      end else if (ctl.emit_char) begin
         emit_idx_ff <= emit_idx_ff + CharIdxW'(1);
      end
      if (ctl.emit_char) begin
         out_char_ff   <= text_rd_ff[{emit_idx_ff, 3'b000} +: CharW];
         last_char_ff  <= emit_last;
         word_error_ff <= 1'b0;
         next_state_ff <= cur_state_ff;
      end else if (ctl.emit_err) begin
         out_char_ff   <= '0;
         last_char_ff  <= 1'b0;
         word_error_ff <= 1'b1;
         next_state_ff <= cur_state_ff;
      end
   end

   always_comb begin
      status.clear_done = (clr_addr_ff == AddrW'(TableDepth - 1));
      status.rejected   = rejected_ff;
      status.no_scan    = (letter_ff >= LetterW'(Alphabet)) || (limit_ff == '0);
      status.hit        = (len_rd_ff != '0);
      status.scan_last  = ((CountW'(dst_ff) + CountW'(1)) == limit_ff);
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.emit_last  = emit_last;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_last_char  = last_char_ff;
   assign rsp_word_error = word_error_ff;
   assign rsp_next_state = next_state_ff;

endmodule

// ===== hdl/finite_state_transducer.sv =====
// ----------------------------------------------------------------------------
// finite_state_transducer
// Table-driven Mealy transducer over the letters a..z.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1664-entry transition table to zero, one
// entry per cycle, and takes no request until the sweep is done (configuration
// writes are taken throughout). A load transaction is written as it is taken,
// and the block stays ready for the next request. A letter passes a start
// step, then one table read and one check on the single read port for each
// destination state scanned, then emits each character or the error
// response, taking no new request meanwhile. A letter of a rejected word
// gives no response. On an error response the consumer discards the word.
// ----------------------------------------------------------------------------
module finite_state_transducer (
   input logic      clock,
   input logic      reset,
   fst_req_if.sink   req_ch,
   fst_rsp_if.source rsp_ch,
   fst_csr_if.sink   csr_ch
);
   import fst_pkg::*;

   ctl_cmd_type    ctl;
   ctl_status_type status;
   fsm_state_type  state;

   assign csr_ch.ready = 1'b1;

   fst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .status    (status),
      .ctl       (ctl),
      .state     (state)
   );

   fst_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .status            (status),
      .req_from_state    (req_ch.from_state),
      .req_to_state      (req_ch.to_state),
      .req_letter        (req_ch.letter),
      .req_first_letter  (req_ch.first_letter),
      .req_out_length    (req_ch.out_length),
      .req_char_position (req_ch.char_position),
      .req_char_value    (req_ch.char_value),
      .csr_wr            (csr_ch.valid && csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_out_char      (rsp_ch.out_char),
      .rsp_last_char     (rsp_ch.last_char),
      .rsp_word_error    (rsp_ch.word_error),
      .rsp_next_state    (rsp_ch.next_state)
   );

   a_clear_blocks_req: assert property (@(posedge clock)
      $past(reset) |-> !req_ch.ready)
      else $error("request taken during table clear");

   a_letter_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.cmd == CMD_LETTER) |=> !req_ch.ready)
      else $error("request taken while a letter is in progress");

   a_error_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.word_error) |-> (!rsp_ch.last_char && rsp_ch.out_char == '0))
      else $error("malformed error response");

   a_emit_only_busy: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit_char || ctl.emit_err) |-> (state == ST_EMIT || state == ST_ERROR))
      else $error("response issued outside emission");

endmodule
